>>> rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the proximity safety evaluator
// Field widths, thresholds, class and reason codes, risk clamp function.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned DistW   = 16;
  localparam int unsigned DecelW  = 15;
  localparam int unsigned SpeedW  = 14;
  localparam int unsigned DoorW   = 10;
  localparam int unsigned BrakeW  = 20;
  localparam int unsigned MarginW = 21;
  localparam int unsigned RiskW   = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned QuoW    = 28;   // quotient width of the divider
  localparam int unsigned NumW    = 28;   // numerator width of the divider
  localparam int unsigned DenW    = 17;   // divisor width

  localparam logic [BrakeW-1:0] BrakeSat  = BrakeW'(1000000);
  localparam logic [16:0]       DivFloor  = 17'd100;
  localparam logic [DistW-1:0]  ContactMm = 16'd100;
  localparam logic [DoorW-1:0]  DoorStop  = 10'd700;
  localparam logic [DoorW-1:0]  DoorWarn  = 10'd250;
  localparam logic [RiskW-1:0]  RiskWarn  = 10'd450;
  localparam logic [RiskW-1:0]  FullRisk  = 10'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WARN  = 2'd0,
    CFG_STOP  = 2'd1,
    CFG_DECEL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_MOVE = 2'd0, CLS_WARNING = 2'd1, CLS_DANGER = 2'd2, CLS_STOP = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    RSN_EMERGENCY = 3'd0, RSN_DOOR = 3'd1, RSN_CONTACT = 3'd2,
    RSN_STOP_AREA = 3'd3, RSN_WARN_AREA = 3'd4, RSN_NORMAL = 3'd5
  } reason_e;

  // Clamp a per-mille quotient to full risk.
  function automatic logic [RiskW-1:0] clamp_risk(input logic [QuoW-1:0] q);
    logic [QuoW-1:0] lim;
    lim = QuoW'(FullRisk);
    clamp_risk = (q > lim) ? FullRisk : q[RiskW-1:0];
  endfunction

endpackage

>>> rtl/pss_if.sv
// ----------------------------------------------------------------------------
// pss_if: valid/ready channel with a generic payload
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface pss_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/proximity_safety_state_evaluator_top.sv
// ----------------------------------------------------------------------------
// proximity_safety_state_evaluator_top: sensor snapshot safety evaluator
// Braking distance, margin, risk score, class, reason and advised speed.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one snapshot per transfer (human/obstacle distance, speed,
//            door opening, estop).
//   out_if : one result per snapshot, in order.
//   cfg    : cfg_we_i/cfg_idx_i/cfg_data_i, write only while idle.
// Throughput: one snapshot per cycle, sustained while results are taken.
// Pipeline: two 28-stage bit-serial division sections in sequence (braking
//   v^2/den, then the three risk ratios, which need the margin).
// The whole pipeline advances as one when the output register is free or
//   being taken, so a stalled receiver freezes every stage; nothing is
//   lost or repeated. Valid bits travel with the data.
// Reset: clears valid bits; registers return to 2000/800/2000.
// ----------------------------------------------------------------------------
module proximity_safety_state_evaluator_top import pss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  pss_if.sink                in_if,
  pss_if.source              out_if
);
  // side band bits carried through the first divider
  typedef struct packed {
    logic [DistW-1:0]  h;
    logic [DistW-1:0]  o;
    logic [SpeedW-1:0] v;
    logic [DoorW-1:0]  door;
    logic              estop;
  } snap_t;

  typedef struct packed {
    snap_t             s;
    logic [BrakeW-1:0] brake;
    logic [DistW-1:0]  near;
    logic [MarginW-1:0] margin;
  } mid_t;

  localparam int unsigned SnapW = $bits(snap_t);
  localparam int unsigned MidW  = $bits(mid_t);
  // ceil(2^18/5): exact floor(x/5) for x below 2^18
  localparam logic [16:0] Recip5 = 17'd52429;

  logic [DistW-1:0]  warn_q, stop_q;
  logic [DecelW-1:0] decel_q;
  logic              adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q  <= 16'd2000;
      stop_q  <= 16'd800;
      decel_q <= 15'd2000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WARN:  warn_q  <= cfg_data_i;
        CFG_STOP:  stop_q  <= cfg_data_i;
        CFG_DECEL: decel_q <= cfg_data_i[DecelW-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: capture snapshot, square speed
  snap_t s0_q;
  logic  vld0_q;
  logic [NumW-1:0] sq_q;
  logic [DenW-1:0] bden_q;
  logic [DenW-1:0] bden_d;
  always_comb begin
    bden_d = {1'b0, decel_q, 1'b0};
    if (bden_d < DivFloor) bden_d = DivFloor;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld0_q <= 1'b0;
    else if (adv) vld0_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.h     <= in_if.data.human_dist;
      s0_q.o     <= in_if.data.obstacle_dist;
      s0_q.v     <= in_if.data.robot_speed;
      s0_q.door  <= in_if.data.door_open;
      s0_q.estop <= in_if.data.estop;
      sq_q       <= NumW'(in_if.data.robot_speed) * NumW'(in_if.data.robot_speed);
      bden_q     <= bden_d;
    end
  end
  assign in_if.ready = adv;

  logic [QuoW-1:0]  bq;
  logic [SnapW-1:0] s1_raw;
  pss_div #(.SideW(SnapW)) u_bdiv (
    .clk_i, .en_i(adv), .num_i(sq_q), .den_i(bden_q),
    .side_i(s0_q), .quo_o(bq), .side_o(s1_raw)
  );
  snap_t s1;
  logic  vld1_q;
  assign s1 = s1_raw;
  // valid bit pipeline needs reset; track it separately
  logic [NumW-1:0] vpipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vpipe_q <= '0;
    else if (adv) vpipe_q <= {vpipe_q[NumW-2:0], vld0_q};
  end

  // stage: saturate brake, margin, risk numerators
  mid_t m_q;
  logic [NumW-1:0] nh_q, no_q, ns_q;
  logic [DenW-1:0] dw_q, ds_q;
  logic            mneg_q;
  logic [BrakeW-1:0] br_d;
  logic [DistW-1:0]  nr_d;
  logic [MarginW-1:0] mg_d;
  logic [DenW-1:0] dw_d, ds_d;
  logic [MarginW:0] sm_d;
  always_comb begin
    br_d = (bq > QuoW'(BrakeSat)) ? BrakeSat : bq[BrakeW-1:0];
    nr_d = (s1.h < s1.o) ? s1.h : s1.o;
    mg_d = MarginW'({5'b0, nr_d}) - MarginW'({1'b0, br_d});
    dw_d = (warn_q < DivFloor[DistW-1:0]) ? DivFloor : {1'b0, warn_q};
    ds_d = (stop_q < DivFloor[DistW-1:0]) ? DivFloor : {1'b0, stop_q};
    sm_d = (MarginW+1)'({6'b0, stop_q}) - (MarginW+1)'(signed'(mg_d));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (adv) vld1_q <= vpipe_q[NumW-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q.s      <= s1;
      m_q.brake  <= br_d;
      m_q.near   <= nr_d;
      m_q.margin <= mg_d;
      mneg_q     <= mg_d[MarginW-1];
      nh_q <= (warn_q > s1.h) ? NumW'(warn_q - s1.h) * NumW'(10'd1000) : '0;
      no_q <= (warn_q > s1.o) ? NumW'(warn_q - s1.o) * NumW'(10'd1000) : '0;
      // only used while the margin is non-negative, then it stays below 2^16
      ns_q <= (!sm_d[MarginW] && sm_d != '0)
              ? NumW'(sm_d[MarginW-1:0]) * NumW'(10'd1000) : '0;
      dw_q <= dw_d;
      ds_q <= ds_d;
    end
  end

  logic [QuoW-1:0] qh, qo, qs;
  logic [MidW:0]   m2_raw;
  logic [MidW:0]   unused0, unused1;
  pss_div #(.SideW(MidW+1)) u_hdiv (
    .clk_i, .en_i(adv), .num_i(nh_q), .den_i(dw_q),
    .side_i({mneg_q, m_q}), .quo_o(qh), .side_o(m2_raw)
  );
  pss_div #(.SideW(MidW+1)) u_odiv (
    .clk_i, .en_i(adv), .num_i(no_q), .den_i(dw_q),
    .side_i({mneg_q, m_q}), .quo_o(qo), .side_o(unused0)
  );
  pss_div #(.SideW(MidW+1)) u_sdiv (
    .clk_i, .en_i(adv), .num_i(ns_q), .den_i(ds_q),
    .side_i({mneg_q, m_q}), .quo_o(qs), .side_o(unused1)
  );
  logic [NumW-1:0] vpipe2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vpipe2_q <= '0;
    else if (adv) vpipe2_q <= {vpipe2_q[NumW-2:0], vld1_q};
  end

  // stage: risk maximum, scaled speeds
  mid_t m2;
  logic mneg2;
  assign {mneg2, m2} = m2_raw;
  logic [RiskW-1:0] rh_d, ro_d, rd_d, rb_d, rk_d;
  logic [SpeedW+3:0]  v9_d;    // 9*v
  logic [SpeedW+1:0]  v9q_d;   // floor(9*v/4)
  logic [SpeedW+16:0] p2_d;
  logic [SpeedW+18:0] p45_d;
  logic [SpeedW-1:0]  v2_d, v45_d;
  always_comb begin
    rh_d = clamp_risk(qh);
    ro_d = clamp_risk(qo);
    rd_d = clamp_risk(QuoW'(m2.s.door));
    rb_d = mneg2 ? FullRisk : clamp_risk(qs);
    rk_d = rh_d;
    if (ro_d > rk_d) rk_d = ro_d;
    if (rd_d > rk_d) rk_d = rd_d;
    if (rb_d > rk_d) rk_d = rb_d;
    if (m2.s.estop) rk_d = FullRisk;
    // v*2/10 = v/5; v*45/100 = floor(floor(9v/4)/5)
    p2_d  = (SpeedW+17)'(m2.s.v) * (SpeedW+17)'(Recip5);
    v2_d  = SpeedW'(p2_d[SpeedW+16:18]);
    v9_d  = {1'b0, m2.s.v, 3'b000} + (SpeedW+4)'(m2.s.v);
    v9q_d = v9_d[SpeedW+3:2];
    p45_d = (SpeedW+19)'(v9q_d) * (SpeedW+19)'(Recip5);
    v45_d = SpeedW'(p45_d[SpeedW+18:18]);
  end
  mid_t m3_q;
  logic [RiskW-1:0] rk_q;
  logic [SpeedW-1:0] v2_q, v45_q;
  logic vld3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld3_q <= 1'b0;
    else if (adv) vld3_q <= vpipe2_q[NumW-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_q  <= m2;
      rk_q  <= rk_d;
      v2_q  <= v2_d;
      v45_q <= v45_d;
    end
  end

  // final stage: classification into output register
  class_e  cls_d;
  reason_e rsn_d;
  logic [SpeedW-1:0] spd_d;
  always_comb begin
    if (m3_q.s.estop || m3_q.s.door >= DoorStop ||
        m3_q.s.h <= ContactMm || m3_q.s.o <= ContactMm) begin
      cls_d = CLS_STOP;
      spd_d = '0;
      rsn_d = m3_q.s.estop ? RSN_EMERGENCY
            : (m3_q.s.door >= DoorStop ? RSN_DOOR : RSN_CONTACT);
    end else if (m3_q.s.h <= stop_q || m3_q.s.o <= stop_q) begin
      cls_d = CLS_DANGER;
      spd_d = (v2_q < SpeedW'(100)) ? SpeedW'(100) : v2_q;
      rsn_d = RSN_STOP_AREA;
    end else if (m3_q.s.h <= warn_q || m3_q.s.o <= warn_q ||
                 m3_q.s.door >= DoorWarn || rk_q >= RiskWarn) begin
      cls_d = CLS_WARNING;
      spd_d = (v45_q < SpeedW'(200)) ? SpeedW'(200) : v45_q;
      rsn_d = RSN_WARN_AREA;
    end else begin
      cls_d = CLS_MOVE;
      spd_d = m3_q.s.v;
      rsn_d = RSN_NORMAL;
    end
  end

  logic out_vld_q;
  assign adv = !out_vld_q || out_if.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= vld3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_if.data.safety_class  <= cls_d;
      out_if.data.reason_code   <= rsn_d;
      out_if.data.brake_dist    <= m3_q.brake;
      out_if.data.nearest_dist  <= m3_q.near;
      out_if.data.margin        <= m3_q.margin;
      out_if.data.risk_score    <= rk_q;
      out_if.data.advised_speed <= spd_d;
    end
  end
  assign out_if.valid = out_vld_q;

  // stall keeps result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed under stall");
  a_stop_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.safety_class == CLS_STOP
    |-> out_if.data.advised_speed == '0)
    else $error("stop class with nonzero speed");
  a_risk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.risk_score <= FullRisk)
    else $error("risk out of range");
endmodule

>>> rtl/pss_div.sv
// ----------------------------------------------------------------------------
// pss_div: pipelined restoring divider
// One quotient bit per stage, NumW stages, advances on enable, sideband rides.
// ----------------------------------------------------------------------------
module pss_div import pss_pkg::*; #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);
  logic [NumW-1:0]  num_q  [NumW+1];
  logic [DenW:0]    rem_q  [NumW+1];
  logic [DenW-1:0]  den_q  [NumW+1];
  logic [SideW-1:0] side_q [NumW+1];

  always_comb begin
    num_q[0]  = num_i;
    rem_q[0]  = '0;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW+1:0] trial;
    logic [DenW:0]   rem_d;
    logic [NumW-1:0] num_d;
    always_comb begin
      trial = {rem_q[k], num_q[k][NumW-1]};
      num_d = {num_q[k][NumW-2:0], 1'b0};
      if (trial >= {1'b0, 1'b0, den_q[k]}) begin
        rem_d    = (DenW+1)'(trial - {2'b0, den_q[k]});
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial[DenW:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1]  <= num_d;
        rem_q[k+1]  <= rem_d;
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign quo_o  = num_q[NumW];
  assign side_o = side_q[NumW];
endmodule

>>> test/proximity_safety_state_evaluator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_safety_state_evaluator_top_test: regression of the safety evaluator
// Directed snapshots at the thresholds, then random snapshots near the zone
// edges under several register settings. Every result is checked against an
// in-bench predictor. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module proximity_safety_state_evaluator_top_test;
  import pss_pkg::*;

  // Payload layouts of the two channels.
  typedef struct packed {
    logic [DistW-1:0]  human_dist;
    logic [DistW-1:0]  obstacle_dist;
    logic [SpeedW-1:0] robot_speed;
    logic [DoorW-1:0]  door_open;
    logic              estop;
  } snapshot_t;

  typedef struct packed {
    logic [1:0]         safety_class;
    logic [2:0]         reason_code;
    logic [BrakeW-1:0]  brake_dist;
    logic [DistW-1:0]   nearest_dist;
    logic [MarginW-1:0] margin;
    logic [RiskW-1:0]   risk_score;
    logic [SpeedW-1:0]  advised_speed;
  } verdict_t;

  // Directed row: fixed class, reason and speed where they are obvious.
  typedef struct {
    snapshot_t  snap;
    bit         fixed;
    class_e     cls;
    reason_e    rsn;
    int         spd;
  } row_t;

  localparam int           Latency    = 2 * NumW + 3;
  localparam logic [1:0]   CfgUnused  = 2'd3;   // index past the register list

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  pss_if #(.T(snapshot_t)) in_if ();
  pss_if #(.T(verdict_t))  out_if ();

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  proximity_safety_state_evaluator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers, updated only while the block is idle.
  int unsigned warn_mm  = 2000;
  int unsigned stop_mm  = 800;
  int unsigned decel_mm = 2000;

  verdict_t  verdict_q[$];
  row_t      fixed_q[$];      // pending typed-in expectations, one per directed row
  int        errors   = 0;
  int        n_sent   = 0;
  int        n_recv   = 0;
  int        n_phase  = 0;
  bit        allow_gaps = 1'b1;

  // Per-mille ratio risk, clamped, divisor floored at 100.
  function automatic longint ratio_permille(longint numer, longint refv);
    longint den;
    den = (refv < 100) ? 100 : refv;
    if (numer <= 0) return 0;
    return ((numer * 1000) / den > 1000) ? 1000 : (numer * 1000) / den;
  endfunction

  function automatic verdict_t evaluate_snapshot(snapshot_t s);
    verdict_t r;
    longint h, o, v, door, w, st, den, brake, near, mrg, risk, rk, spd;
    h = s.human_dist; o = s.obstacle_dist; v = s.robot_speed; door = s.door_open;
    w = warn_mm; st = stop_mm;
    den = 2 * longint'(decel_mm);
    if (den < 100) den = 100;
    brake = (v * v) / den;
    if (brake > 1000000) brake = 1000000;
    near = (h < o) ? h : o;
    mrg  = near - brake;
    risk = ratio_permille(w - h, w);
    rk = ratio_permille(w - o, w);
    if (rk > risk) risk = rk;
    rk = (door > 1000) ? 1000 : door;
    if (rk > risk) risk = rk;
    rk = (mrg < 0) ? 1000 : ratio_permille(st - mrg, st);
    if (rk > risk) risk = rk;
    if (s.estop) risk = 1000;
    if (s.estop || door >= 700 || h <= 100 || o <= 100) begin
      r.safety_class = CLS_STOP;
      spd = 0;
      r.reason_code = s.estop ? RSN_EMERGENCY : (door >= 700 ? RSN_DOOR : RSN_CONTACT);
    end else if (h <= st || o <= st) begin
      r.safety_class = CLS_DANGER;
      spd = (v * 2) / 10;
      if (spd < 100) spd = 100;
      r.reason_code = RSN_STOP_AREA;
    end else if (h <= w || o <= w || door >= 250 || risk >= 450) begin
      r.safety_class = CLS_WARNING;
      spd = (v * 45) / 100;
      if (spd < 200) spd = 200;
      r.reason_code = RSN_WARN_AREA;
    end else begin
      r.safety_class = CLS_MOVE;
      spd = v;
      r.reason_code = RSN_NORMAL;
    end
    r.brake_dist    = BrakeW'(brake);
    r.nearest_dist  = DistW'(near);
    r.margin        = MarginW'(mrg);
    r.risk_score    = RiskW'(risk);
    r.advised_speed = SpeedW'(spd);
    return r;
  endfunction

  // Input monitor: every transfer queues its expected verdict.
  always @(posedge clk_i) begin
    verdict_t e;
    row_t     fr;
    if (rst_ni && in_if.valid && in_if.ready) begin
      e = evaluate_snapshot(in_if.data);
      if (fixed_q.size() > 0 && in_if.data == fixed_q[0].snap) begin
        // Typed-in fields replace the predicted ones for directed rows.
        fr = fixed_q.pop_front();
        if (fr.fixed) begin
          e.safety_class  = fr.cls;
          e.reason_code   = fr.rsn;
          e.advised_speed = SpeedW'(fr.spd);
        end
      end
      verdict_q.push_back(e);
      n_sent++;
    end
  end

  // Output monitor: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_recv++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_if.data);
      end else begin
        e = verdict_q.pop_front();
        if (out_if.data !== e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch #%0d: exp %p got %p", n_recv, e, out_if.data);
        end
      end
    end
  end

  // Receiver stalls: mostly short bursts, now and then a long hold.
  int hold = 0;
  always @(posedge clk_i) begin
    if (hold > 0) begin
      hold <= hold - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
      hold <= ($urandom_range(0, 12) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDatW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WARN:  warn_mm  = val & 16'hFFFF;
      CFG_STOP:  stop_mm  = val & 16'hFFFF;
      CFG_DECEL: decel_mm = val & 15'h7FFF;
      default: ;
    endcase
  endtask

  // Wait until every result is back, then let the pipeline settle.
  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic send_snapshot(snapshot_t s);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (allow_gaps) begin
      gap = $urandom_range(0, 15);
      gap = (gap == 0) ? $urandom_range(20, 60) : (gap < 8 ? 0 : $urandom_range(1, 3));
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic idle_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Distance picked near a zone edge most of the time.
  function automatic logic [DistW-1:0] pick_dist();
    int unsigned sel, base;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    base = warn_mm;
      2, 3:    base = stop_mm;
      4:       base = 100;
      5:       return DistW'($urandom_range(0, 200));
      default: return DistW'($urandom());
    endcase
    return DistW'(int'(base) + $urandom_range(0, 40) - 20);
  endfunction

  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    s.human_dist    = pick_dist();
    s.obstacle_dist = ($urandom_range(0, 2) == 0) ? DistW'($urandom()) : pick_dist();
    s.robot_speed   = ($urandom_range(0, 7) == 0) ? SpeedW'($urandom())
                                                  : SpeedW'($urandom_range(0, 10000));
    s.door_open     = ($urandom_range(0, 3) == 0) ? DoorW'($urandom())
                                                  : DoorW'($urandom_range(0, 300));
    s.estop         = ($urandom_range(0, 15) == 0);
    return s;
  endfunction

  function automatic row_t mk(int h, int o, int v, int d, bit e,
                              bit fx, class_e c, reason_e rs, int sp);
    row_t r;
    r.snap  = '{DistW'(h), DistW'(o), SpeedW'(v), DoorW'(d), e};
    r.fixed = fx; r.cls = c; r.rsn = rs; r.spd = sp;
    return r;
  endfunction

  row_t rows[$];

  initial begin
    int unsigned w, st, dc;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed rows against the reset settings (2000 / 800 / 2000).
    rows.push_back(mk(0, 0, 0, 0, 0, 1, CLS_STOP, RSN_CONTACT, 0));
    rows.push_back(mk(65535, 65535, 0, 0, 1, 1, CLS_STOP, RSN_EMERGENCY, 0));
    rows.push_back(mk(65535, 65535, 0, 700, 0, 1, CLS_STOP, RSN_DOOR, 0));
    rows.push_back(mk(65535, 65535, 16383, 1023, 0, 1, CLS_STOP, RSN_DOOR, 0));
    rows.push_back(mk(65535, 65535, 10000, 0, 0, 1, CLS_MOVE, RSN_NORMAL, 10000));
    rows.push_back(mk(65535, 65535, 16383, 0, 0, 0, CLS_MOVE, RSN_NORMAL, 0));
    rows.push_back(mk(100, 65535, 500, 0, 0, 1, CLS_STOP, RSN_CONTACT, 0));
    rows.push_back(mk(65535, 101, 500, 0, 0, 0, CLS_DANGER, RSN_STOP_AREA, 0));
    rows.push_back(mk(800, 65535, 0, 0, 0, 1, CLS_DANGER, RSN_STOP_AREA, 100));
    rows.push_back(mk(801, 65535, 3000, 0, 0, 0, CLS_WARNING, RSN_WARN_AREA, 0));
    rows.push_back(mk(2000, 2000, 0, 0, 0, 1, CLS_WARNING, RSN_WARN_AREA, 200));
    rows.push_back(mk(2001, 2001, 4000, 0, 0, 0, CLS_MOVE, RSN_NORMAL, 0));
    rows.push_back(mk(65535, 65535, 0, 249, 0, 1, CLS_MOVE, RSN_NORMAL, 0));
    rows.push_back(mk(65535, 65535, 0, 250, 0, 1, CLS_WARNING, RSN_WARN_AREA, 200));
    rows.push_back(mk(65535, 65535, 0, 699, 0, 1, CLS_WARNING, RSN_WARN_AREA, 200));
    rows.push_back(mk(65535, 65535, 0, 1000, 1, 1, CLS_STOP, RSN_EMERGENCY, 0));
    rows.push_back(mk(3000, 2500, 9000, 0, 0, 0, CLS_MOVE, RSN_NORMAL, 0));
    rows.push_back(mk(1200, 40000, 8000, 100, 0, 0, CLS_MOVE, RSN_NORMAL, 0));
    rows.push_back(mk(0, 65535, 16383, 1023, 1, 1, CLS_STOP, RSN_EMERGENCY, 0));
    rows.push_back(mk(43690, 21845, 5461, 682, 0, 0, CLS_MOVE, RSN_NORMAL, 0));
    foreach (rows[i]) begin
      fixed_q.push_back(rows[i]);
      send_snapshot(rows[i].snap);
    end
    idle_input();
    drain();

    // Random phases under several settings, extremes first.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin w = 0;     st = 0;     dc = 0;     end  // every divisor floored
        1: begin w = 65535; st = 65535; dc = 32767; end
        2: begin w = 2000;  st = 800;   dc = 20000; end
        3: begin w = 150;   st = 60;    dc = 40;    end  // tiny values, saturating brake
        default: begin
          w = $urandom_range(0, 8000); st = $urandom_range(0, 3000);
          dc = $urandom_range(0, 20000);
        end
      endcase
      write_reg(CFG_WARN, w);
      write_reg(CFG_STOP, st);
      write_reg(CFG_DECEL, dc);
      if (ph == 2) write_reg(CfgUnused, $urandom());   // must be ignored
      allow_gaps = (ph != 4);
      n_phase++;
      for (int k = 0; k < 175; k++) begin
        send_snapshot(random_snapshot());
        if (ph == 5 && k == 90) begin
          // Hold the sender until the pipeline is empty.
          idle_input();
          while (verdict_q.size() != 0) @(posedge clk_i);
        end
      end
      idle_input();
      drain();
    end

    $display("Covered %0d snapshots (%0d directed) over %0d register settings.",
             n_sent, rows.size(), n_phase + 1);
    $display("Results checked: %0d, mismatches: %0d.", n_recv, errors);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout after %0d of %0d results", n_recv, n_sent);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> proximity_safety_state_evaluator_top.f
rtl/pss_pkg.sv
rtl/pss_if.sv
rtl/pss_div.sv
rtl/proximity_safety_state_evaluator_top.sv
test/proximity_safety_state_evaluator_top_test.sv
